// ----- src/tps_pkg.sv -----
// Package: shared types and constants for the tristate pair subtractor.
`timescale 1ns / 1ps

package tps_pkg;

    localparam int WORD_WIDTH    = 32;
    localparam int PREFIX_LEVELS = $clog2(WORD_WIDTH);

    typedef logic [WORD_WIDTH-1:0] word_t;

    // One input item as held in the input register.
    typedef struct packed {
        word_t z_val0;
        word_t z_known0;
        word_t z_val1;
        word_t z_known1;
        word_t z_diff_known;
        word_t z_diff_val;
        word_t y_val0;
        word_t y_known0;
        word_t y_val1;
        word_t y_known1;
        word_t y_diff_known;
        word_t y_diff_val;
    } in_item_t;

    // One result item as held in the output register.
    typedef struct packed {
        word_t v_val0;
        word_t v_known0;
        word_t v_val1;
        word_t v_known1;
        word_t v_diff_known;
        word_t v_diff_val;
        word_t borrow_known0;
        word_t borrow_val0;
        word_t borrow_known1;
        word_t borrow_val1;
    } out_item_t;

    // Result of one instance lane.
    typedef struct packed {
        word_t v_val;
        word_t v_known;
        word_t borrow_known;
        word_t borrow_val;
    } lane_res_t;

endpackage

// ----- src/tps_in_if.sv -----
// Interface: input channel carrying one operand pair item.
`timescale 1ns / 1ps

interface tps_in_if
    import tps_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t z_val0;
    word_t z_known0;
    word_t z_val1;
    word_t z_known1;
    word_t z_diff_known;
    word_t z_diff_val;
    word_t y_val0;
    word_t y_known0;
    word_t y_val1;
    word_t y_known1;
    word_t y_diff_known;
    word_t y_diff_val;

    modport source (
        output valid,
        input  ready,
        output z_val0, z_known0, z_val1, z_known1, z_diff_known, z_diff_val,
        output y_val0, y_known0, y_val1, y_known1, y_diff_known, y_diff_val
    );

    modport sink (
        input  valid,
        output ready,
        input  z_val0, z_known0, z_val1, z_known1, z_diff_known, z_diff_val,
        input  y_val0, y_known0, y_val1, y_known1, y_diff_known, y_diff_val
    );
endinterface

// ----- src/tps_out_if.sv -----
// Interface: output channel carrying one difference result item.
`timescale 1ns / 1ps

interface tps_out_if
    import tps_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t v_val0;
    word_t v_known0;
    word_t v_val1;
    word_t v_known1;
    word_t v_diff_known;
    word_t v_diff_val;
    word_t borrow_known0;
    word_t borrow_val0;
    word_t borrow_known1;
    word_t borrow_val1;

    modport source (
        output valid,
        input  ready,
        output v_val0, v_known0, v_val1, v_known1, v_diff_known, v_diff_val,
        output borrow_known0, borrow_val0, borrow_known1, borrow_val1
    );

    modport sink (
        input  valid,
        output ready,
        input  v_val0, v_known0, v_val1, v_known1, v_diff_known, v_diff_val,
        input  borrow_known0, borrow_val0, borrow_known1, borrow_val1
    );
endinterface

// ----- src/tps_sub_lane.sv -----
// Module: known-bits subtraction of one instance with prefix borrow resolution.
`timescale 1ns / 1ps

module tps_sub_lane
    import tps_pkg::*;
(
    input  word_t     zv,
    input  word_t     zk,
    input  word_t     yv,
    input  word_t     yk,
    output lane_res_t res
);

    word_t both;
    word_t dif;
    word_t pass;
    word_t np;
    word_t allpass;
    word_t g;
    word_t b;
    word_t p;
    word_t bk;
    word_t bv;

    always_comb
    begin
        both = yk & zk;
        dif  = yv ^ zv;
        pass = ~dif & both;
        g    = dif & both;          // known differing bits generate a known borrow
        b    = yv & dif & both;
        p    = pass;
        // Kogge-Stone prefix over generate/propagate
        for (int l = 0; l < PREFIX_LEVELS; l++)
        begin
            g = g | (p & (g << (1 << l)));
            b = b | (p & (b << (1 << l)));
            p = p & (p << (1 << l));
        end
        // bits strictly below the lowest non-pass bit; all ones if every bit passes
        np      = ~pass;
        allpass = (np ^ (np - word_t'(1))) & ~np;

        bk = ((g | allpass) << 1) | word_t'(1);
        bv = b << 1;

        res.v_val        = yv ^ zv ^ bv;
        res.v_known      = both & bk;
        res.borrow_known = bk;
        res.borrow_val   = bv;
    end

endmodule

// ----- src/tristate_pair_subtractor.sv -----
// Top level: tristate pair subtractor, two instance lanes with registered in/out.
`timescale 1ns / 1ps
//
// Usage
//   in_ch  (sink):   one item = two three-valued operand word pairs z and y,
//                    each with two value/known instances and a known xor
//                    difference between them.
//   out_ch (source): one item = v = z - y per instance with known masks, the
//                    per-bit borrow-in masks of both instances, and the xor
//                    difference of the result with its known mask.
//   An item moves on a rising edge with valid and ready both high.
// Path: an item taken goes into the input register, then through the prefix
//   borrow logic into the result register, which presents it on out_ch.
// Throughput: 1 item per cycle while out_ch.ready is high; set by the single
//   registered pass through the 5-level borrow prefix network of each lane.
// Stall: when out_ch.ready is low a full result register holds; the input
//   register still takes an item while the result register is free or
//   draining, so up to two items are held inside before in_ch.ready drops.
// Reset: rst_n (async, active low) empties both stages; no state otherwise.
//

module tristate_pair_subtractor
    import tps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tps_in_if.sink       in_ch,
    tps_out_if.source    out_ch
);

    // stage 1: input register
    logic      in_valid_reg;
    in_item_t  in_reg;
    // stage 2: result register
    logic      out_valid_reg;
    out_item_t out_reg;

    logic      out_adv;     // result register loads
    logic      in_adv;      // input register loads
    lane_res_t res0;
    lane_res_t res1;
    out_item_t out_next;

    assign out_adv     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_adv      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !in_valid_reg || out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_adv)
        begin
            in_reg.z_val0       <= in_ch.z_val0;
            in_reg.z_known0     <= in_ch.z_known0;
            in_reg.z_val1       <= in_ch.z_val1;
            in_reg.z_known1     <= in_ch.z_known1;
            in_reg.z_diff_known <= in_ch.z_diff_known;
            in_reg.z_diff_val   <= in_ch.z_diff_val;
            in_reg.y_val0       <= in_ch.y_val0;
            in_reg.y_known0     <= in_ch.y_known0;
            in_reg.y_val1       <= in_ch.y_val1;
            in_reg.y_known1     <= in_ch.y_known1;
            in_reg.y_diff_known <= in_ch.y_diff_known;
            in_reg.y_diff_val   <= in_ch.y_diff_val;
        end
        if (out_adv)
        begin
            out_reg <= out_next;
        end
    end

    // one lane per instance
    tps_sub_lane u_lane0 (
        .zv  (in_reg.z_val0),
        .zk  (in_reg.z_known0),
        .yv  (in_reg.y_val0),
        .yk  (in_reg.y_known0),
        .res (res0)
    );

    tps_sub_lane u_lane1 (
        .zv  (in_reg.z_val1),
        .zk  (in_reg.z_known1),
        .yv  (in_reg.y_val1),
        .yk  (in_reg.y_known1),
        .res (res1)
    );

    always_comb
    begin
        out_next.v_val0        = res0.v_val;
        out_next.v_known0      = res0.v_known;
        out_next.v_val1        = res1.v_val;
        out_next.v_known1      = res1.v_known;
        // the result difference is known only where both borrows are known too
        out_next.v_diff_known  = in_reg.y_diff_known & in_reg.z_diff_known
                               & res0.borrow_known & res1.borrow_known;
        out_next.v_diff_val    = in_reg.y_diff_val ^ in_reg.z_diff_val
                               ^ res0.borrow_val ^ res1.borrow_val;
        out_next.borrow_known0 = res0.borrow_known;
        out_next.borrow_val0   = res0.borrow_val;
        out_next.borrow_known1 = res1.borrow_known;
        out_next.borrow_val1   = res1.borrow_val;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.v_val0        = out_reg.v_val0;
    assign out_ch.v_known0      = out_reg.v_known0;
    assign out_ch.v_val1        = out_reg.v_val1;
    assign out_ch.v_known1      = out_reg.v_known1;
    assign out_ch.v_diff_known  = out_reg.v_diff_known;
    assign out_ch.v_diff_val    = out_reg.v_diff_val;
    assign out_ch.borrow_known0 = out_reg.borrow_known0;
    assign out_ch.borrow_val0   = out_reg.borrow_val0;
    assign out_ch.borrow_known1 = out_reg.borrow_known1;
    assign out_ch.borrow_val1   = out_reg.borrow_val1;

    // borrow into bit 0 is always known
    a_borrow0_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.borrow_known0[0] && out_reg.borrow_known1[0]))
        else $error("borrow into bit 0 not known");

    // a borrow value is only set where it is known
    a_borrow_val_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((out_reg.borrow_val0 & ~out_reg.borrow_known0) == '0)
                       && ((out_reg.borrow_val1 & ~out_reg.borrow_known1) == '0)))
        else $error("borrow value set where borrow unknown");

    // a known result bit needs a known borrow
    a_known_needs_borrow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((out_reg.v_known0 & ~out_reg.borrow_known0) == '0)
                       && ((out_reg.v_known1 & ~out_reg.borrow_known1) == '0)))
        else $error("result known without known borrow");

    // an item leaving the input register shows up as a result next cycle
    a_stage_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        out_adv |=> out_valid_reg)
        else $error("item lost between stages");

endmodule
